### design/sparse_image_chunk_sequencer_assert.svh
// Assertion macros used by the sparse image chunk sequencer checker.
`ifndef SPARSE_IMAGE_CHUNK_SEQUENCER_ASSERT_SVH
`define SPARSE_IMAGE_CHUNK_SEQUENCER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SISC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sisc assertion failed: implication");

// A stalled transaction keeps valid high and its payload unchanged.
`define SISC_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
		else $error("sisc assertion failed: stalled transaction changed");

`endif

### design/sisc_pkg.sv
// Types, codes and constants of the sparse image chunk sequencer.
`default_nettype none

package sisc_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITION  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED   = 3'd3;

	localparam logic [16:0] BLOCK_SIZE_RST = 17'd4096;
	localparam logic [15:0] HEADER_RST     = 16'd12;
	localparam logic [16:0] FILL_BYTES     = 17'd4;
	localparam logic [31:0] WORD_MAX       = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		KC_RAW,
		KC_FILL,
		KC_DONT_CARE,
		KC_CRC,
		KC_UNKNOWN
	} kind_cls_t;

	typedef enum logic [1:0] {
		ACT_COPY,
		ACT_FILL,
		ACT_SKIP,
		ACT_NONE
	} action_t;

	typedef enum logic [3:0] {
		ST_OK,
		ST_FULL,
		ST_SIZE_OVF,
		ST_TOO_LARGE,
		ST_BAD_RAW,
		ST_BAD_FILL,
		ST_BAD_CRC,
		ST_POS_OVF,
		ST_UNKNOWN,
		ST_MISMATCH,
		ST_IMG_LARGE,
		ST_ABORTED
	} status_t;

	typedef struct packed {
		kind_cls_t   kind;
		logic [31:0] blocks;
		logic [31:0] total;
		logic [31:0] pattern;
		logic        last;
	} chunk_t;

	typedef struct packed {
		logic [16:0] block_size;
		logic [47:0] partition;
		logic [15:0] header;
		logic [31:0] expected;
	} cfg_t;

	function automatic kind_cls_t classify(input logic [2:0] code);
		kind_cls_t k;
		unique case (code)
			3'd0:    k = KC_RAW;
			3'd1:    k = KC_FILL;
			3'd2:    k = KC_DONT_CARE;
			3'd3:    k = KC_CRC;
			default: k = KC_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

### design/sisc_chunk_if.sv
// Chunk header channel: valid, ready and one decoded chunk header.
`default_nettype none

interface sisc_chunk_if;
	logic        valid;
	logic        ready;
	logic [2:0]  chunk_kind;
	logic [31:0] chunk_blocks;
	logic [31:0] chunk_total_bytes;
	logic [31:0] pattern_word;
	logic        final_chunk;

	modport source (
		output valid, chunk_kind, chunk_blocks, chunk_total_bytes, pattern_word, final_chunk,
		input  ready
	);
	modport sink (
		input  valid, chunk_kind, chunk_blocks, chunk_total_bytes, pattern_word, final_chunk,
		output ready
	);
endinterface

`default_nettype wire

### design/sisc_cmd_if.sv
// Command channel: valid, ready and one block command with status.
`default_nettype none

interface sisc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] start_block;
	logic [31:0] block_count;
	logic [31:0] pattern_out;
	logic [3:0]  status;
	logic        image_done;

	modport source (
		output valid, action, start_block, block_count, pattern_out, status, image_done,
		input  ready
	);
	modport sink (
		input  valid, action, start_block, block_count, pattern_out, status, image_done,
		output ready
	);
endinterface

`default_nettype wire

### design/sisc_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
`default_nettype none

interface sisc_cfg_if;
	import sisc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/sisc_front.sv
// Front end: accepts chunk headers, classifies the kind and queues them.
`default_nettype none

module sisc_front
	import sisc_pkg::*;
#(
	parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sisc_chunk_if.sink   chunk,
	output chunk_t       head,
	output logic         head_valid,
	input  logic         head_pop
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	chunk_t          entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;
	chunk_t          incoming;

	assign chunk.ready = (count_q != CntW'(QueueDepth));
	assign head_valid  = (count_q != '0);
	assign head        = entry_q[rd_ptr_q];
	assign push        = chunk.valid && chunk.ready;
	assign pop         = head_pop && head_valid;

	always_comb begin
		incoming.kind    = classify(chunk.chunk_kind);
		incoming.blocks  = chunk.chunk_blocks;
		incoming.total   = chunk.chunk_total_bytes;
		incoming.pattern = chunk.pattern_word;
		incoming.last    = chunk.final_chunk;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/sisc_back.sv
// Back end: byte products, bound and size checks, position update, command register.
`default_nettype none

module sisc_back
	import sisc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  chunk_t      head,
	input  logic        head_valid,
	output logic        head_pop,
	sisc_cmd_if.source  cmd
);

	// stage 2 holds one header with its byte products
	logic        s2_valid_q;
	chunk_t      item_s2;
	logic [48:0] pos_prod_s2;
	logic [48:0] chunk_prod_s2;
	logic [48:0] img_prod_s2;

	logic [31:0] pos_q;
	logic        aborted_q;

	logic        out_valid_q;
	action_t     act_q;
	logic [31:0] start_q;
	logic [31:0] count_q;
	logic [31:0] pat_q;
	status_t     status_q;
	logic        done_q;

	logic        fire;
	logic [49:0] end_bytes;
	logic [32:0] raw_need;
	logic [16:0] fill_need;
	logic [32:0] pos_sum;

	logic        kind_fail;
	status_t     kind_st;
	action_t     kind_act;

	logic        fail;
	logic        advance;
	logic        done;
	logic        mismatch;
	action_t     act;
	status_t     st;
	logic [31:0] pat;

	assign head_pop = head_valid && !s2_valid_q;
	assign fire     = s2_valid_q && (!out_valid_q || cmd.ready);

	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_s2       <= head;
			pos_prod_s2   <= {17'b0, pos_q} * {32'b0, cfg.block_size};
			chunk_prod_s2 <= {17'b0, head.blocks} * {32'b0, cfg.block_size};
			img_prod_s2   <= {17'b0, cfg.expected} * {32'b0, cfg.block_size};
		end
	end

	assign end_bytes = {1'b0, pos_prod_s2} + {1'b0, chunk_prod_s2};
	assign raw_need  = {1'b0, chunk_prod_s2[31:0]} + {17'b0, cfg.header};
	assign fill_need = {1'b0, cfg.header} + FILL_BYTES;
	assign pos_sum   = {1'b0, pos_q} + {1'b0, item_s2.blocks};

	always_comb begin
		kind_fail = 1'b0;
		kind_st   = ST_OK;
		kind_act  = ACT_NONE;
		unique case (item_s2.kind)
			KC_RAW: begin
				kind_act  = ACT_COPY;
				kind_fail = ({1'b0, item_s2.total} != raw_need);
				kind_st   = ST_BAD_RAW;
			end
			KC_FILL: begin
				kind_act  = ACT_FILL;
				kind_fail = (item_s2.total != {15'b0, fill_need});
				kind_st   = ST_BAD_FILL;
			end
			KC_DONT_CARE: begin
				kind_act  = ACT_SKIP;
			end
			KC_CRC: begin
				kind_act  = ACT_SKIP;
				kind_fail = (item_s2.total != {16'b0, cfg.header});
				kind_st   = ST_BAD_CRC;
			end
			default: begin
				kind_fail = 1'b1;
				kind_st   = ST_UNKNOWN;
			end
		endcase
	end

	always_comb begin
		fail     = 1'b0;
		advance  = 1'b0;
		done     = 1'b0;
		mismatch = 1'b0;
		act      = ACT_NONE;
		st       = ST_OK;
		priority if (aborted_q) begin
			st = ST_ABORTED;
		end else if (img_prod_s2 > {1'b0, cfg.partition}) begin
			fail = 1'b1;
			st   = ST_IMG_LARGE;
		end else if (pos_prod_s2 >= {1'b0, cfg.partition}) begin
			fail = 1'b1;
			st   = ST_FULL;
		end else if (chunk_prod_s2 > {17'b0, WORD_MAX}) begin
			fail = 1'b1;
			st   = ST_SIZE_OVF;
		end else if (end_bytes > {2'b0, cfg.partition}) begin
			fail = 1'b1;
			st   = ST_TOO_LARGE;
		end else if (kind_fail) begin
			fail = 1'b1;
			st   = kind_st;
		end else if (pos_sum[32]) begin
			fail = 1'b1;
			st   = ST_POS_OVF;
		end else begin
			advance = 1'b1;
			act     = kind_act;
			if (item_s2.last) begin
				if (pos_sum[31:0] == cfg.expected) begin
					done = 1'b1;
				end else begin
					mismatch = 1'b1;
					st       = ST_MISMATCH;
				end
			end
		end
		pat = (act == ACT_FILL) ? item_s2.pattern : '0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_q    <= act;
			start_q  <= pos_q;
			count_q  <= (act == ACT_NONE) ? '0 : item_s2.blocks;
			pat_q    <= pat;
			status_q <= st;
			done_q   <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			aborted_q   <= 1'b0;
		end else begin
			if (head_pop) begin
				s2_valid_q <= 1'b1;
			end else if (fire) begin
				s2_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && advance) begin
				pos_q <= done ? '0 : pos_sum[31:0];
			end
			if (fire && (fail || mismatch)) begin
				aborted_q <= 1'b1;
			end
		end
	end

	assign cmd.valid       = out_valid_q;
	assign cmd.action      = act_q;
	assign cmd.start_block = start_q;
	assign cmd.block_count = count_q;
	assign cmd.pattern_out = pat_q;
	assign cmd.status      = status_q;
	assign cmd.image_done  = done_q;

endmodule

`default_nettype wire

### design/sparse_image_chunk_sequencer.sv
// Sparse image chunk sequencer: top level with configuration registers.
//
// Takes one decoded sparse-image chunk header per transaction and returns one
// block command per header. The front end queues up to QueueDepth classified
// headers; the back end resolves one header at a time: a first step forms
// the byte products (position, chunk and image against the block size), and
// the second runs the bound and size checks, updates the block position and
// loads the command register. The block position feeds the next header's
// product, so the back end pops no header until the last has left stage 2. A
// header passes the queue, stage 2 and the command register. A failed check
// answers with action none; a failure or final-chunk mismatch sets a sticky
// abort and every later header reports aborted until reset. Configuration
// writes are always taken and must only be issued while no header is in flight.
`default_nettype none

module sparse_image_chunk_sequencer
	import sisc_pkg::*;
#(
	parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sisc_chunk_if.sink  chunk,
	sisc_cmd_if.source  cmd,
	sisc_cfg_if.sink    cfg
);

	cfg_t   cfg_q;
	chunk_t head;
	logic   head_valid;
	logic   head_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size <= BLOCK_SIZE_RST;
			cfg_q.partition  <= '0;
			cfg_q.header     <= HEADER_RST;
			cfg_q.expected   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_BLOCK_SIZE: cfg_q.block_size <= cfg.data[16:0];
				CFG_PARTITION:  cfg_q.partition  <= cfg.data[47:0];
				CFG_HEADER:     cfg_q.header     <= cfg.data[15:0];
				CFG_EXPECTED:   cfg_q.expected   <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	sisc_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chunk     (chunk),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop)
	);

	sisc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.cmd       (cmd)
	);

endmodule

`default_nettype wire

### design/sisc_checker.sv
// Port-level assertions of the sparse image chunk sequencer and their bind.
`default_nettype none
`include "sparse_image_chunk_sequencer_assert.svh"

module sisc_checker
	import sisc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  action,
	input logic [31:0] start_block,
	input logic [31:0] block_count,
	input logic [31:0] pattern_out,
	input logic [3:0]  status,
	input logic        image_done
);

	logic [102:0] cmd_payload;
	logic         none_act;
	logic         none_clean;
	logic         done_ok;
	logic         err_st;

	assign cmd_payload = {action, start_block, block_count, pattern_out, status, image_done};
	assign none_act    = cmd_valid && (action == ACT_NONE);
	assign none_clean  = (block_count == '0) && (pattern_out == '0) && !image_done;
	assign done_ok     = (status == ST_OK) && (action != ACT_NONE);
	assign err_st      = cmd_valid && (status != ST_OK) && (status != ST_MISMATCH);

	`SISC_ASSERT_HOLD(a_cmd_hold, clk, arst_n, cmd_valid, cmd_ready, cmd_payload)

	`SISC_ASSERT_IMPLY(a_none_empty, clk, arst_n, none_act, none_clean)

	`SISC_ASSERT_IMPLY(a_done_ok, clk, arst_n, cmd_valid && image_done, done_ok)

	`SISC_ASSERT_IMPLY(a_error_none, clk, arst_n, err_st, action == ACT_NONE)

endmodule

bind sparse_image_chunk_sequencer sisc_checker u_sisc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.action     (cmd.action),
	.start_block(cmd.start_block),
	.block_count(cmd.block_count),
	.pattern_out(cmd.pattern_out),
	.status     (cmd.status),
	.image_done (cmd.image_done)
);

`default_nettype wire
